// ----- hdl/aip_pkg.sv -----
`timescale 1ns / 1ps

package aip_pkg;

    // Widths of the data path.
    localparam int VALUE_WIDTH    = 32;
    localparam int INDEX_WIDTH    = 16;
    localparam int RADIX_WIDTH    = 6;
    localparam int DIGIT_WIDTH    = 6;
    localparam int CHAR_WIDTH     = 8;
    localparam int CFG_ADDR_WIDTH = 1;
    localparam int OUT_DATA_WIDTH = VALUE_WIDTH + INDEX_WIDTH;

    // Queue between the classifier and the parser.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RADIX  = 1'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SIGNED = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET  = 6'd10;
    localparam logic                   SIGNED_RESET = 1'b1;

    // Radix codes used by the parser.
    localparam logic [RADIX_WIDTH-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_WIDTH-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_WIDTH-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_HEX  = 6'd16;

    // Character codes.
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_WIDTH-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_WIDTH-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [DIGIT_WIDTH-1:0] LETTER_BASE = 6'd10;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // One classified character as it travels through the queue.
    typedef struct packed {
        logic                   blank;
        logic                   minus;
        logic                   plus;
        logic                   zero;
        logic                   xch;
        logic                   dig_ok;
        logic [DIGIT_WIDTH-1:0] digit;
        logic                   last;
    } t_item;

    // Handshake between the queue and the parser.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

// ----- hdl/ascii_integer_parser_unit.sv -----
`timescale 1ns / 1ps

// ASCII integer parser. Characters stream in one word per cycle on the slave
// side while the queue has room, with tlast on the final character of each
// string; every string gives exactly one result word on the master side: the
// parsed value, the index of the first character not consumed and a flag for
// digits found. Leading blanks are skipped, an optional plus sign is taken, a
// minus sign only while the signed register is set, and the radix comes from
// the radix register (zero selects auto-detection from a 0x or leading-zero
// prefix). The block sustains one character per cycle unless the queue fills
// or the output is blocked: the front classifier feeds a four-word queue, and
// the parser behind it does one multiply-add by the radix per character. The
// parser handles a character once it reaches the queue head, and a result it
// causes is offered from the edge that takes it; the parser only stalls when a
// result is due while the output register still holds one not taken.
// Configuration writes must be made while no string is in flight.
module ascii_integer_parser_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration port
    input  logic                                   i_cfg_we,
    input  logic [aip_pkg::CFG_ADDR_WIDTH-1:0]     i_cfg_addr,
    input  logic [aip_pkg::RADIX_WIDTH-1:0]        i_cfg_data,
    // Character stream in
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [aip_pkg::CHAR_WIDTH-1:0]         i_s_tdata,   // [7:0] character
    input  logic                                   i_s_tlast,   // last_char
    // Result stream out
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [aip_pkg::OUT_DATA_WIDTH-1:0]     o_m_tdata,   // [31:0] value, [47:32] end_index
    output logic                                   o_m_tuser    // digits_found
);

    logic [aip_pkg::RADIX_WIDTH-1:0]  r_radix;
    logic                             r_signed;
    logic                             w_full;
    logic                             w_push;
    aip_pkg::t_item                   w_item;
    aip_pkg::t_head                   w_head;
    logic                             w_pop;
    logic [aip_pkg::VALUE_WIDTH-1:0]  w_value;
    logic [aip_pkg::INDEX_WIDTH-1:0]  w_index;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= aip_pkg::RADIX_RESET;
            r_signed <= aip_pkg::SIGNED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                aip_pkg::CFG_RADIX:  r_radix  <= i_cfg_data;
                aip_pkg::CFG_SIGNED: r_signed <= i_cfg_data[0];
                default: begin
                    r_radix <= r_radix;
                end
            endcase
        end
    end

    aip_front u_front (
        .i_valid (i_s_tvalid),
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_full  (w_full),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_item  (w_item)
    );

    aip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    aip_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_radix        (r_radix),
        .i_signed       (r_signed),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_value        (w_value),
        .o_end_index    (w_index),
        .o_digits_found (o_m_tuser)
    );

    assign o_m_tdata = {w_index, w_value};

endmodule

// ----- hdl/aip_front.sv -----
`timescale 1ns / 1ps

module aip_front (
    input  logic                              i_valid,
    input  logic [aip_pkg::CHAR_WIDTH-1:0]    i_char,
    input  logic                              i_last,
    input  logic                              i_full,
    output logic                              o_ready,
    output logic                              o_push,
    output aip_pkg::t_item                    o_item
);

    logic [aip_pkg::CHAR_WIDTH-1:0] w_off;

    // A word is taken whenever the queue has room.
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Classify the character: blanks, sign, prefix letters and digit value.
    always_comb begin
        w_off = '0;
        o_item = '0;
        o_item.last  = i_last;
        o_item.blank = (i_char == aip_pkg::CH_SPACE) || (i_char == aip_pkg::CH_TAB)
                    || (i_char == aip_pkg::CH_LF) || (i_char == aip_pkg::CH_VT)
                    || (i_char == aip_pkg::CH_FF) || (i_char == aip_pkg::CH_CR);
        o_item.minus = (i_char == aip_pkg::CH_MINUS);
        o_item.plus  = (i_char == aip_pkg::CH_PLUS);
        o_item.zero  = (i_char == aip_pkg::CH_ZERO);
        o_item.xch   = (i_char == aip_pkg::CH_LO_X) || (i_char == aip_pkg::CH_UP_X);
        if (i_char >= aip_pkg::CH_ZERO && i_char <= aip_pkg::CH_NINE) begin
            w_off = i_char - aip_pkg::CH_ZERO;
            o_item.dig_ok = 1'b1;
            o_item.digit  = w_off[aip_pkg::DIGIT_WIDTH-1:0];
        end else if (i_char >= aip_pkg::CH_LO_A && i_char <= aip_pkg::CH_LO_Z) begin
            w_off = i_char - aip_pkg::CH_LO_A;
            o_item.dig_ok = 1'b1;
            o_item.digit  = w_off[aip_pkg::DIGIT_WIDTH-1:0] + aip_pkg::LETTER_BASE;
        end else if (i_char >= aip_pkg::CH_UP_A && i_char <= aip_pkg::CH_UP_Z) begin
            w_off = i_char - aip_pkg::CH_UP_A;
            o_item.dig_ok = 1'b1;
            o_item.digit  = w_off[aip_pkg::DIGIT_WIDTH-1:0] + aip_pkg::LETTER_BASE;
        end
    end

endmodule

// ----- hdl/aip_fifo.sv -----
`timescale 1ns / 1ps

module aip_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  aip_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output aip_pkg::t_head o_head
);

    aip_pkg::t_item                 r_mem [aip_pkg::FIFO_DEPTH];
    logic [aip_pkg::FIFO_AW-1:0]    r_wr;
    logic [aip_pkg::FIFO_AW-1:0]    r_rd;
    logic [aip_pkg::FIFO_CW-1:0]    r_count;
    logic [aip_pkg::FIFO_CW-1:0]    n_count;

    assign o_full       = (r_count == aip_pkg::FIFO_CW'(aip_pkg::FIFO_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ----- hdl/aip_back.sv -----
`timescale 1ns / 1ps

module aip_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [aip_pkg::RADIX_WIDTH-1:0]       i_radix,
    input  logic                                  i_signed,
    input  aip_pkg::t_head                        i_head,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [aip_pkg::VALUE_WIDTH-1:0]       o_value,
    output logic [aip_pkg::INDEX_WIDTH-1:0]       o_end_index,
    output logic                                  o_digits_found
);

    aip_pkg::t_phase                        r_phase;
    aip_pkg::t_phase                        n_phase;
    aip_pkg::t_phase                        w_raw_phase;
    logic                                   r_neg;
    logic                                   n_neg;
    logic [aip_pkg::VALUE_WIDTH-1:0]        r_acc;
    logic [aip_pkg::VALUE_WIDTH-1:0]        n_acc;
    logic [aip_pkg::RADIX_WIDTH-1:0]        r_wrad;
    logic [aip_pkg::RADIX_WIDTH-1:0]        n_wrad;
    logic                                   r_anyd;
    logic                                   n_anyd;
    logic [aip_pkg::INDEX_WIDTH-1:0]        r_pos;
    logic [aip_pkg::INDEX_WIDTH-1:0]        n_pos;
    logic                                   w_adv;

    logic                                   r_out_valid;
    logic [aip_pkg::VALUE_WIDTH-1:0]        r_out_value;
    logic [aip_pkg::INDEX_WIDTH-1:0]        r_out_index;
    logic                                   r_out_digits;

    aip_pkg::t_item                         w_it;
    logic                                   w_start_zero;
    logic [aip_pkg::RADIX_WIDTH-1:0]        w_start_r;
    logic                                   w_start_dig;
    logic                                   w_cont_dig;
    logic [aip_pkg::VALUE_WIDTH-1:0]        w_mac;
    logic                                   w_ended;
    logic                                   w_emit;
    logic                                   w_stall;
    logic [aip_pkg::VALUE_WIDTH-1:0]        w_value;
    logic [aip_pkg::INDEX_WIDTH-1:0]        w_index;

    // Decisions shared by the state machine and the data path.
    assign w_it         = i_head.item;
    assign w_start_zero = w_it.zero
                       && ((i_radix == aip_pkg::RADIX_AUTO) || (i_radix == aip_pkg::RADIX_HEX));
    assign w_start_r    = (i_radix == aip_pkg::RADIX_AUTO) ? aip_pkg::RADIX_DEC : i_radix;
    assign w_start_dig  = w_it.dig_ok && (w_it.digit < w_start_r);
    assign w_cont_dig   = w_it.dig_ok && (w_it.digit < r_wrad);

    // One multiply-add step by the working radix.
    assign w_mac = r_acc * aip_pkg::VALUE_WIDTH'(r_wrad)
                 + aip_pkg::VALUE_WIDTH'(w_it.digit);

    // Next phase of the parse.
    always_comb begin
        case (r_phase)
            aip_pkg::PH_SPACE: begin
                if (w_it.blank) begin
                    w_raw_phase = aip_pkg::PH_SPACE;
                end else if (w_it.minus) begin
                    w_raw_phase = i_signed ? aip_pkg::PH_START : aip_pkg::PH_DONE;
                end else if (w_it.plus) begin
                    w_raw_phase = aip_pkg::PH_START;
                end else if (w_start_zero) begin
                    w_raw_phase = aip_pkg::PH_ZERO;
                end else begin
                    w_raw_phase = w_start_dig ? aip_pkg::PH_DIGITS : aip_pkg::PH_DONE;
                end
            end
            aip_pkg::PH_START: begin
                if (w_start_zero) begin
                    w_raw_phase = aip_pkg::PH_ZERO;
                end else begin
                    w_raw_phase = w_start_dig ? aip_pkg::PH_DIGITS : aip_pkg::PH_DONE;
                end
            end
            aip_pkg::PH_ZERO: begin
                w_raw_phase = (w_it.xch || w_cont_dig) ? aip_pkg::PH_DIGITS
                                                       : aip_pkg::PH_DONE;
            end
            aip_pkg::PH_DIGITS: begin
                w_raw_phase = w_cont_dig ? aip_pkg::PH_DIGITS : aip_pkg::PH_DONE;
            end
            default: begin
                w_raw_phase = aip_pkg::PH_DONE;
            end
        endcase
        w_ended = (w_raw_phase == aip_pkg::PH_DONE) && (r_phase != aip_pkg::PH_DONE);
        w_emit  = (r_phase != aip_pkg::PH_DONE) && (w_ended || w_it.last);
        if (w_it.last) begin
            n_phase = aip_pkg::PH_SPACE;
        end else if (w_emit) begin
            n_phase = aip_pkg::PH_DONE;
        end else begin
            n_phase = w_raw_phase;
        end
    end

    // Data path updates for the character at the head of the queue.
    always_comb begin
        n_neg  = r_neg;
        n_acc  = r_acc;
        n_wrad = r_wrad;
        n_anyd = r_anyd;
        w_adv  = 1'b0;
        case (r_phase)
            aip_pkg::PH_SPACE, aip_pkg::PH_START: begin
                if (r_phase == aip_pkg::PH_SPACE && w_it.blank) begin
                    w_adv = 1'b1;
                end else if (r_phase == aip_pkg::PH_SPACE && w_it.minus) begin
                    n_neg = i_signed;
                    w_adv = i_signed;
                end else if (r_phase == aip_pkg::PH_SPACE && w_it.plus) begin
                    w_adv = 1'b1;
                end else if (w_start_zero) begin
                    n_wrad = (i_radix == aip_pkg::RADIX_AUTO) ? aip_pkg::RADIX_OCT
                                                              : aip_pkg::RADIX_HEX;
                    n_acc  = '0;
                    n_anyd = 1'b1;
                    w_adv  = 1'b1;
                end else begin
                    // The accumulator is still zero here, so the digit is the value.
                    n_wrad = w_start_r;
                    if (w_start_dig) begin
                        n_acc  = aip_pkg::VALUE_WIDTH'(w_it.digit);
                        n_anyd = 1'b1;
                        w_adv  = 1'b1;
                    end
                end
            end
            aip_pkg::PH_ZERO, aip_pkg::PH_DIGITS: begin
                if (r_phase == aip_pkg::PH_ZERO && w_it.xch) begin
                    n_wrad = aip_pkg::RADIX_HEX;
                    n_acc  = '0;
                    n_anyd = 1'b0;
                    w_adv  = 1'b1;
                end else if (w_cont_dig) begin
                    n_acc  = w_mac;
                    n_anyd = 1'b1;
                    w_adv  = 1'b1;
                end
            end
            default: begin
                w_adv = 1'b0;
            end
        endcase
        n_pos = (w_adv && (r_pos != '1)) ? r_pos + 1'b1 : r_pos;
        // A minus sign with no digit behind it points the end back at the sign.
        w_index = (!n_anyd && n_neg && (n_pos != '0) && (n_pos != '1)) ? n_pos - 1'b1
                                                                         : n_pos;
        w_value = n_neg ? (~n_acc + 1'b1) : n_acc;
    end

    // The queue head is taken unless a result is due and the output is blocked.
    assign w_stall = w_emit && r_out_valid && !i_ready;
    assign o_pop   = i_head.valid && !w_stall;

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aip_pkg::PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_wrad  <= '0;
            r_anyd  <= 1'b0;
            r_pos   <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            if (w_it.last) begin
                r_neg  <= 1'b0;
                r_acc  <= '0;
                r_wrad <= '0;
                r_anyd <= 1'b0;
                r_pos  <= '0;
            end else begin
                r_neg  <= n_neg;
                r_acc  <= n_acc;
                r_wrad <= n_wrad;
                r_anyd <= n_anyd;
                r_pos  <= n_pos;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_out_value  <= w_value;
            r_out_index  <= w_index;
            r_out_digits <= n_anyd;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_value        = r_out_value;
    assign o_end_index    = r_out_index;
    assign o_digits_found = r_out_digits;

endmodule

// ----- hdl/aip_checker.sv -----
`timescale 1ns / 1ps

module aip_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [aip_pkg::OUT_DATA_WIDTH-1:0]  i_out_data,
    input  logic                                i_out_user
);

    // A result waiting to be taken stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // A result waiting to be taken keeps its contents.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data) && $stable(i_out_user))
        else $error("result changed while stalled");

    // Without any digit the value is zero, also after a minus sign.
    a_no_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_user |-> i_out_data[aip_pkg::VALUE_WIDTH-1:0] == '0)
        else $error("non-zero value reported without digits");

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result offered straight after reset");

endmodule

bind ascii_integer_parser_unit aip_checker u_aip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_m_tvalid),
    .i_out_ready (i_m_tready),
    .i_out_data  (o_m_tdata),
    .i_out_user  (o_m_tuser)
);
